// ===== rtl/cvh_pkg.sv =====
package cvh_pkg;

    // item commands
    localparam logic CMD_INT   = 1'b0;
    localparam logic CMD_QUANT = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NAN   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // fnv-1a 64 constants: prime = 2^40 + 0x1b3
    localparam logic [63:0] CVH_OFFSET_BASIS = 64'd14695981039346656037;
    localparam logic [16:0] CVH_FNV_LOW      = 17'h001b3;
    localparam int          CVH_FNV_SHIFT    = 40;

    // fixed-point scale
    localparam logic [16:0] CVH_SCALE = 17'd100000;

    // byte count saturation
    localparam logic [3:0] CVH_MAX_BYTES = 4'd8;

    // double exponent bias plus mantissa width
    localparam logic [10:0] CVH_EXP_ZERO = 11'd1075;
    localparam logic [10:0] CVH_EXP_DEN  = 11'd1074;
    localparam logic [10:0] CVH_EXP_INF  = 11'h7ff;

    // widths of the scaled product and the rounded value
    localparam int CVH_PROD_W = 70;
    localparam int CVH_Q_W    = 71;

endpackage

// ===== rtl/cvh_mul.sv =====
module cvh_mul
    import cvh_pkg::*;
(
    input  logic [63:0] a,
    input  logic [16:0] b,
    output logic [80:0] p
);

    // shared 64 x 17 multiplier, caller registers the result
    assign p = 81'(a) * 81'(b);

endmodule

// ===== rtl/cvh_align.sv =====
module cvh_align
    import cvh_pkg::*;
(
    input  logic [CVH_PROD_W-1:0] prod,
    input  logic [10:0]           exp_field,
    output logic [CVH_Q_W-1:0]    q,
    output logic                  ovf
);

    logic        lsh_case;
    logic [10:0] lamt;
    logic [10:0] ramt;
    logic [6:0]  rsat;
    logic [131:0] lwide;
    logic [CVH_Q_W-1:0] rwide;

    // left shift for large exponents, right shift with rounding otherwise
    assign lsh_case = exp_field >= CVH_EXP_ZERO;
    assign lamt     = exp_field - CVH_EXP_ZERO;
    assign ramt     = (exp_field == 11'd0) ? CVH_EXP_DEN : (CVH_EXP_ZERO - exp_field);
    assign rsat     = (ramt > 11'd71) ? 7'd71 : ramt[6:0];
    assign lwide    = {62'b0, prod} << lamt[5:0];
    // extra low bit keeps the half bit for rounding
    assign rwide    = {prod, 1'b0} >> rsat;

    always_comb begin
        if (lsh_case) begin
            ovf = (lamt >= 11'd63) || (|lwide[131:71]);
            q   = lwide[70:0];
        end else begin
            ovf = 1'b0;
            q   = {1'b0, rwide[CVH_Q_W-1:1]} + CVH_Q_W'(rwide[0]);
        end
    end

endmodule

// ===== rtl/canonical_value_hasher_unit.sv =====
// integer item with n bytes (n = 0..8): S_ABSORB takes the n bytes, then S_DONE posts the result
// quantize: MUL, ROUND, CHECK, ABSORB, DONE; non-finite skips to DONE; out of range skips ABSORB
// throughput: one item at a time; the shared 64 x 17 multiplier absorbs one byte per cycle
// a new request is taken once the block is idle and the result register is free or draining
// reset: aresetn synchronous active low, hash reloads the fnv offset basis, no result pending
module canonical_value_hasher_unit
    import cvh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,  // value_bits[63:0], byte_count[67:64], restart[68], zero pad
    input  logic         s_tuser,  // command[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // hash_value[63:0], fixed_value[127:64]
    output logic [1:0]   m_tuser   // status[1:0]
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_ROUND  = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_ABSORB = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]  state_reg;
    logic [63:0] hash_reg;
    logic [63:0] data_reg;
    logic [3:0]  cnt_reg;
    logic        neg_reg;
    logic [10:0] exp_reg;
    logic [CVH_PROD_W-1:0] prod_reg;
    logic [CVH_Q_W-1:0]    q_reg;
    logic        ovf_reg;
    logic [1:0]  status_reg;
    logic [63:0] fixed_reg;

    logic        m_valid_reg;
    logic [63:0] m_hash_reg;
    logic [63:0] m_fixed_reg;
    logic [1:0]  m_status_reg;

    logic        accept;
    logic [63:0] in_value;
    logic [3:0]  in_count;
    logic        in_restart;
    logic [3:0]  cnt_sat;
    logic [63:0] hash_base;

    logic [63:0] mul_a;
    logic [16:0] mul_b;
    logic [80:0] mul_p;
    logic [63:0] fnv_x;
    logic [63:0] hash_step;

    logic [CVH_Q_W-1:0] align_q;
    logic               align_ovf;
    logic [CVH_Q_W-1:0] limit;
    logic               range_err;

    // input unpacking
    assign in_value   = s_tdata[63:0];
    assign in_count   = s_tdata[67:64];
    assign in_restart = s_tdata[68];
    assign cnt_sat    = (in_count > CVH_MAX_BYTES) ? CVH_MAX_BYTES : in_count;
    assign hash_base  = in_restart ? CVH_OFFSET_BASIS : hash_reg;

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // shared multiplier: mantissa scaling or fnv byte round
    assign fnv_x = hash_reg ^ {56'b0, data_reg[7:0]};
    assign mul_a = (state_reg == S_MUL) ? {11'b0, data_reg[52:0]} : fnv_x;
    assign mul_b = (state_reg == S_MUL) ? CVH_SCALE : CVH_FNV_LOW;

    cvh_mul u_mul (
        .a (mul_a),
        .b (mul_b),
        .p (mul_p)
    );

    assign hash_step = mul_p[63:0] + (fnv_x << CVH_FNV_SHIFT);

    // exponent alignment and rounding of the scaled product
    cvh_align u_align (
        .prod      (prod_reg),
        .exp_field (exp_reg),
        .q         (align_q),
        .ovf       (align_ovf)
    );

    // range check against the signed 64-bit limit
    assign limit     = neg_reg ? (CVH_Q_W'(1) << 63) : ((CVH_Q_W'(1) << 63) - CVH_Q_W'(1));
    assign range_err = ovf_reg || (q_reg > limit);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            hash_reg    <= CVH_OFFSET_BASIS;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        hash_reg   <= hash_base;
                        status_reg <= ST_OK;
                        fixed_reg  <= 64'd0;
                        neg_reg    <= in_value[63];
                        exp_reg    <= in_value[62:52];
                        if (s_tuser == CMD_INT) begin
                            data_reg  <= in_value;
                            cnt_reg   <= cnt_sat;
                            state_reg <= (cnt_sat == 4'd0) ? S_DONE : S_ABSORB;
                        end else if (in_value[62:52] == CVH_EXP_INF) begin
                            status_reg <= ST_NAN;
                            state_reg  <= S_DONE;
                        end else begin
                            data_reg <= (in_value[62:52] == 11'd0)
                                ? {12'b0, in_value[51:0]}
                                : {11'b0, 1'b1, in_value[51:0]};
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    prod_reg  <= mul_p[CVH_PROD_W-1:0];
                    state_reg <= S_ROUND;
                end
                S_ROUND: begin
                    q_reg     <= align_q;
                    ovf_reg   <= align_ovf;
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    if (range_err) begin
                        status_reg <= ST_RANGE;
                        state_reg  <= S_DONE;
                    end else begin
                        fixed_reg <= neg_reg ? (64'd0 - q_reg[63:0]) : q_reg[63:0];
                        data_reg  <= neg_reg ? (64'd0 - q_reg[63:0]) : q_reg[63:0];
                        cnt_reg   <= CVH_MAX_BYTES;
                        state_reg <= S_ABSORB;
                    end
                end
                S_ABSORB: begin
                    hash_reg <= hash_step;
                    data_reg <= data_reg >> 8;
                    cnt_reg  <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE) begin
            m_hash_reg   <= hash_reg;
            m_fixed_reg  <= fixed_reg;
            m_status_reg <= status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_fixed_reg, m_hash_reg};
    assign m_tuser  = m_status_reg;

endmodule

// ===== rtl/cvh_checker.sv =====
module cvh_checker
    import cvh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [71:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [1:0]   m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item at a time: busy right after a request
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // a request is only taken when the result slot is free or draining
    a_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid || m_tready)
        else $error("request taken over a pending result");

    // an error result carries zero fixed value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_OK |-> m_tdata[127:64] == 64'd0)
        else $error("error result with nonzero fixed value");

    // no unused status code
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_NAN || m_tuser == ST_RANGE)
        else $error("invalid status code");

endmodule

bind canonical_value_hasher_unit cvh_checker u_cvh_checker (.*);

// ===== verif/cvh_hash_checker.sv =====
`timescale 1ns / 1ps

module cvh_hash_checker
    import cvh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [71:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           pending_count
);

    typedef struct packed {
        logic        command;
        logic [63:0] value_bits;
        logic [3:0]  byte_count;
        logic        restart;
    } hash_request_t;

    typedef struct packed {
        logic [63:0] hash_value;
        logic [1:0]  status;
        logic [63:0] fixed_value;
    } hash_result_t;

    localparam logic [63:0]  FNV_PRIME   = 64'd1099511628211;
    localparam logic [127:0] FIXED_SCALE = 128'd100000;

    logic [63:0]  model_hash;
    hash_result_t expected_results[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
        model_hash    = CVH_OFFSET_BASIS;
    end

    // fold the low n bytes of v into the hash, least significant byte first
    function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [63:0] v,
                                               input int unsigned n);
        logic [63:0] acc;
        acc = h;
        for (int i = 0; i < n; i++)
            acc = (acc ^ {56'd0, v[8*i +: 8]}) * FNV_PRIME;
        return acc;
    endfunction

    // exact double * 100000, rounded half away from zero, range checked
    function automatic hash_result_t quantize_scaled(input logic [63:0] bits);
        hash_result_t res;
        logic         neg;
        logic [10:0]  exp_field;
        logic [52:0]  mant;
        int           exp2;
        int           k;
        logic [127:0] prod;
        logic [127:0] q;
        logic [127:0] limit;
        logic         rnd;
        res       = '0;
        neg       = bits[63];
        exp_field = bits[62:52];
        if (exp_field == CVH_EXP_INF) begin
            res.status = ST_NAN;
            return res;
        end
        mant = (exp_field == 11'd0) ? {1'b0, bits[51:0]} : {1'b1, bits[51:0]};
        exp2 = (exp_field == 11'd0) ? -1074 : int'(exp_field) - 1075;
        res.status = ST_OK;
        if (mant == 53'd0)
            return res;
        limit = neg ? 128'h8000_0000_0000_0000 : 128'h7fff_ffff_ffff_ffff;
        prod  = 128'(mant) * FIXED_SCALE;
        if (exp2 >= 0) begin
            if (exp2 >= 63 || prod[127:64] != 64'd0 || prod > (limit >> exp2)) begin
                res.status = ST_RANGE;
                return res;
            end
            q = prod << exp2;
        end else begin
            k   = -exp2;
            q   = (k >= 128) ? 128'd0 : (prod >> k);
            rnd = 1'b0;
            if (k - 1 < 128)
                rnd = prod[k-1];
            q = q + 128'(rnd);
            if (q > limit) begin
                res.status = ST_RANGE;
                return res;
            end
        end
        res.fixed_value = neg ? (64'd0 - q[63:0]) : q[63:0];
        return res;
    endfunction

    // predict on accepted requests, compare on accepted results
    always @(posedge aclk) begin : watch
        hash_request_t req;
        hash_result_t  want;
        hash_result_t  got;
        int unsigned   nbytes;
        if (!aresetn) begin
            model_hash = CVH_OFFSET_BASIS;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                req.command    = s_tuser;
                req.value_bits = s_tdata[63:0];
                req.byte_count = s_tdata[67:64];
                req.restart    = s_tdata[68];
                if (req.restart)
                    model_hash = CVH_OFFSET_BASIS;
                if (req.command == CMD_INT) begin
                    want   = '0;
                    nbytes = (req.byte_count > CVH_MAX_BYTES) ? CVH_MAX_BYTES : req.byte_count;
                    model_hash = fnv_absorb(model_hash, req.value_bits, nbytes);
                end else begin
                    want = quantize_scaled(req.value_bits);
                    if (want.status == ST_OK)
                        model_hash = fnv_absorb(model_hash, want.fixed_value, 8);
                end
                want.hash_value = model_hash;
                expected_results.insert(expected_results.size(), want);
            end
            if (m_tvalid && m_tready) begin
                got.hash_value  = m_tdata[63:0];
                got.fixed_value = m_tdata[127:64];
                got.status      = m_tuser;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result hash %h status %0d fixed %h",
                             $time, got.hash_value, got.status, got.fixed_value);
                end else begin
                    want = expected_results.pop_front();
                    if (got.hash_value !== want.hash_value) begin
                        fail_count++;
                        $display("%0t: hash_value expected %h actual %h",
                                 $time, want.hash_value, got.hash_value);
                    end
                    if (got.status !== want.status) begin
                        fail_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.fixed_value !== want.fixed_value) begin
                        fail_count++;
                        $display("%0t: fixed_value expected %h actual %h",
                                 $time, want.fixed_value, got.fixed_value);
                    end
                end
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== verif/canonical_value_hasher_unit_tb.sv =====
`timescale 1ns / 1ps

module canonical_value_hasher_unit_tb;
    import cvh_pkg::*;

    localparam int PHASE_REQUESTS = 300;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata  = '0;
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    int fail_count;
    int pending_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holds_asked    = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    canonical_value_hasher_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    cvh_hash_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result side: random stalls, plus a long hold-off on demand
    always @(negedge aclk) begin
        if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no traffic on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // offer one request, with random gaps before it, until accepted
    task automatic send_request(input logic cmd, input logic [63:0] bits,
                                input logic [3:0] nbytes, input logic rst);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, rst, nbytes, bits};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // double bits spread over the interesting regions of the quantizer
    function automatic logic [63:0] random_double();
        int          sel;
        logic [63:0] raw;
        logic [10:0] e;
        real         r;
        sel = $urandom_range(99);
        raw = {$urandom, $urandom};
        if (sel < 55) begin
            // ordinary magnitudes that quantize cleanly
            e = 11'($urandom_range(1023 - 20, 1023 + 45));
            return {raw[63], e, raw[51:0]};
        end else if (sel < 65) begin
            // around the signed 64-bit limit
            e = 11'($urandom_range(1023 + 44, 1023 + 48));
            return {raw[63], e, raw[51:0]};
        end else if (sel < 75) begin
            return raw;
        end else if (sel < 83) begin
            return {raw[63], CVH_EXP_INF, raw[51:0]};
        end else if (sel < 91) begin
            // denormals and tiny values, most too small to survive rounding
            e = 11'($urandom_range(0, 1023 - 17));
            return {raw[63], e, raw[51:0]};
        end else begin
            // odd multiple of 1/64 lands exactly halfway after scaling
            r   = real'(2 * $urandom_range(0, 500000) + 1) / 64.0;
            raw = $realtobits(r);
            return {$urandom_range(1) == 1, raw[62:0]};
        end
    endfunction

    task automatic send_random();
        logic [63:0] bits;
        logic [3:0]  nbytes;
        logic        rst;
        bits   = {$urandom, $urandom};
        nbytes = ($urandom_range(9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 8));
        rst    = ($urandom_range(15) == 0);
        if ($urandom_range(1) == 0)
            send_request(CMD_INT, bits, nbytes, rst);
        else
            send_request(CMD_QUANT, random_double(), nbytes, rst);
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // integer extremes and byte counts
        send_request(CMD_INT, 64'd0, 4'd8, 1'b0);
        send_request(CMD_INT, 64'hffff_ffff_ffff_ffff, 4'd8, 1'b0);
        send_request(CMD_INT, 64'h0123_4567_89ab_cdef, 4'd0, 1'b0);
        send_request(CMD_INT, 64'h0123_4567_89ab_cdef, 4'd1, 1'b0);
        send_request(CMD_INT, 64'hfedc_ba98_7654_3210, 4'd3, 1'b1);
        send_request(CMD_INT, 64'h8000_0000_0000_0001, 4'd9, 1'b0);
        send_request(CMD_INT, 64'h5555_aaaa_5555_aaaa, 4'd15, 1'b0);
        // quantize: zeros, units, exact halves
        send_request(CMD_QUANT, 64'h0000_0000_0000_0000, 4'd0, 1'b0);
        send_request(CMD_QUANT, 64'h8000_0000_0000_0000, 4'd0, 1'b0);
        send_request(CMD_QUANT, $realtobits(1.0), 4'd0, 1'b0);
        send_request(CMD_QUANT, $realtobits(-1.0), 4'd0, 1'b0);
        send_request(CMD_QUANT, $realtobits(0.046875), 4'd0, 1'b0);
        send_request(CMD_QUANT, $realtobits(-0.046875), 4'd0, 1'b0);
        // tiny values
        send_request(CMD_QUANT, 64'h0000_0000_0000_0001, 4'd0, 1'b0);
        send_request(CMD_QUANT, $realtobits(-1.5e-300), 4'd0, 1'b0);
        // not finite
        send_request(CMD_QUANT, 64'h7ff0_0000_0000_0000, 4'd0, 1'b0);
        send_request(CMD_QUANT, 64'hfff0_0000_0000_0000, 4'd0, 1'b0);
        send_request(CMD_QUANT, 64'h7ff8_0000_0000_0001, 4'd0, 1'b0);
        // near and past the fixed-point range
        send_request(CMD_QUANT, $realtobits(92233720368547.75), 4'd0, 1'b0);
        send_request(CMD_QUANT, $realtobits(-92233720368547.75), 4'd0, 1'b0);
        send_request(CMD_QUANT, $realtobits(1.0e14), 4'd0, 1'b0);
        send_request(CMD_QUANT, 64'h43e0_0000_0000_0000, 4'd0, 1'b0);
        send_request(CMD_QUANT, 64'h7fef_ffff_ffff_ffff, 4'd0, 1'b0);
        // restart together with an error
        send_request(CMD_QUANT, 64'hfff8_0000_0000_0000, 4'd0, 1'b1);
        send_request(CMD_QUANT, $realtobits(3.25), 4'd0, 1'b1);

        // random phases: none, sender idle, receiver stall, both light
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = (p == 1) ? 71 : (p == 3) ? 6 : 0;
            recv_stall_pct = (p == 2) ? 71 : (p == 3) ? 6 : 0;
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (p == 0 && n == 60)
                    holds_asked++;
                send_random();
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
